### sv/mg3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mg3_pkg - shared types and constants of the 3x3 morphological gradient
// Pixel, column and reduction types, register indexes, result slot positions
// and the small min/max helpers used by the cells and the top level.
// ----------------------------------------------------------------------------
package mg3_pkg;

	localparam int PIX_W            = 8;
	localparam int FRAME_WIDTH_W    = 11;
	localparam int FRAME_HEIGHT_W   = 13;
	localparam int CFG_DATA_W       = 13;
	localparam int CFG_IDX_W        = 2;
	localparam int OUT_ROW_W        = 12;
	localparam int OUT_COL_W        = 10;

	localparam int DEF_MAX_WIDTH    = 1024;
	localparam int DEF_MAX_HEIGHT   = 4096;
	localparam int RST_FRAME_WIDTH  = 1024;
	localparam int RST_FRAME_HEIGHT = 4096;

	localparam int NUM_CELLS        = 3;
	localparam int NUM_SLOTS        = 4;

	// result slots of one item, in output order
	localparam int SLOT_ABOVE_LEFT  = 0;
	localparam int SLOT_ABOVE       = 1;
	localparam int SLOT_LEFT        = 2;
	localparam int SLOT_HERE        = 3;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

	typedef logic [PIX_W-1:0] pixel_t;

	typedef struct packed {
		pixel_t older;
		pixel_t prev;
	} line_pair_t;

	typedef struct packed {
		pixel_t top;
		pixel_t mid;
		pixel_t bot;
		logic   top_ok;
		logic   mid_ok;
	} column_t;

	typedef struct packed {
		pixel_t lo_all;
		pixel_t hi_all;
		pixel_t lo_low;
		pixel_t hi_low;
	} col_red_t;

	typedef struct packed {
		logic row_ge1;
		logic row_ge2;
		logic col_ge1;
		logic col_ge2;
	} pos_flags_t;

	function automatic pixel_t pix_min(input pixel_t a, input pixel_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pixel_t pix_max(input pixel_t a, input pixel_t b);
		return (a > b) ? a : b;
	endfunction

endpackage

### sv/morphological_gradient_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morphological_gradient_3x3 - 3x3 max minus min over a raster pixel stream
// Path: an item goes from its accept through stage 1 and stage 2 (with the
// window cells) to the output register; its further results follow one per cycle while out_ready allows.
// Results: an item gives 0 to 4 results through the single output register;
// interior pixels run one per cycle while out_ready is high.
// Reset: frame size to 1024 x 4096 (clamped), position to zero; line store
// contents are not cleared, no clearing pass.
// ----------------------------------------------------------------------------
module morphological_gradient_3x3 import mg3_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIX_W-1:0]      pixel,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIX_W-1:0]      gradient,
	output logic [OUT_ROW_W-1:0]  out_row,
	output logic [OUT_COL_W-1:0]  out_col,
	output logic                  last_of_run,
	output logic                  frame_end
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int W_RST = (RST_FRAME_WIDTH < MAX_WIDTH) ? RST_FRAME_WIDTH : MAX_WIDTH;
	localparam int H_RST = (RST_FRAME_HEIGHT < MAX_HEIGHT) ? RST_FRAME_HEIGHT : MAX_HEIGHT;

	logic [CW-1:0]        w_last_q, w_last_c, col_q;
	logic [RW-1:0]        h_last_q, h_last_c, row_q;
	logic [31:0]          w_req, h_req;

	logic                 accept, last_row_c, last_col_c;
	pos_flags_t           flags_c;
	logic [NUM_SLOTS-1:0] pend_c;

	logic                 s1_valid_q, s1_adv;
	pixel_t               pixel_s1;
	logic [RW-1:0]        row_s1;
	logic [CW-1:0]        col_s1;
	pos_flags_t           flags_s1;
	logic [NUM_SLOTS-1:0] pend_s1;

	line_pair_t           rd_pair, new_pair;
	column_t              col_new;
	column_t              col_chain [NUM_CELLS];
	col_red_t             red [NUM_CELLS];

	logic [NUM_SLOTS-1:0] pend_s2, sel, rest;
	logic [RW-1:0]        row_s2, r_c;
	logic [CW-1:0]        col_s2, c_c;
	pos_flags_t           flags_s2;
	logic                 above, left, inc0, inc1, emit, s2_free;
	pixel_t               mn, mx;
	logic [31:0]          r_wide, c_wide;

	logic                 out_valid_q, last_q, fend_q;
	pixel_t               grad_q;
	logic [OUT_ROW_W-1:0] row_out_q;
	logic [OUT_COL_W-1:0] col_out_q;

	// configuration clamp
	always_comb begin
		w_req = 32'(cfg_data[FRAME_WIDTH_W-1:0]);
		if (w_req == 32'd0) begin
			w_req = 32'd1;
		end else if (w_req > 32'(MAX_WIDTH)) begin
			w_req = 32'(MAX_WIDTH);
		end
		w_last_c = CW'(w_req - 32'd1);
		h_req = 32'(cfg_data[FRAME_HEIGHT_W-1:0]);
		if (h_req == 32'd0) begin
			h_req = 32'd1;
		end else if (h_req > 32'(MAX_HEIGHT)) begin
			h_req = 32'(MAX_HEIGHT);
		end
		h_last_c = RW'(h_req - 32'd1);
	end

	assign accept   = in_valid && in_ready;
	assign in_ready = !s1_valid_q || s1_adv;

	// position of the incoming item
	assign last_row_c      = (row_q == h_last_q);
	assign last_col_c      = (col_q == w_last_q);
	assign flags_c.row_ge1 = (row_q != '0);
	assign flags_c.row_ge2 = (row_q > RW'(1));
	assign flags_c.col_ge1 = (col_q != '0);
	assign flags_c.col_ge2 = (col_q > CW'(1));

	always_comb begin
		pend_c                  = '0;
		pend_c[SLOT_ABOVE_LEFT] = flags_c.row_ge1 && flags_c.col_ge1;
		pend_c[SLOT_ABOVE]      = flags_c.row_ge1 && last_col_c;
		pend_c[SLOT_LEFT]       = last_row_c && flags_c.col_ge1;
		pend_c[SLOT_HERE]       = last_row_c && last_col_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= CW'(W_RST - 1);
			h_last_q <= RW'(H_RST - 1);
			row_q    <= '0;
			col_q    <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH: begin
					w_last_q <= w_last_c;
					row_q    <= '0;
					col_q    <= '0;
				end
				REG_FRAME_HEIGHT: begin
					h_last_q <= h_last_c;
					row_q    <= '0;
					col_q    <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (last_col_c) begin
				col_q <= '0;
				row_q <= last_row_c ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// stage 1: item waits for its line store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixel;
			row_s1   <= row_q;
			col_s1   <= col_q;
			flags_s1 <= flags_c;
			pend_s1  <= pend_c;
		end
	end

	assign s1_adv   = s1_valid_q && s2_free;
	assign new_pair = '{older: rd_pair.prev, prev: pixel_s1};

	mg3_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_store (
		.clk      (clk),
		.rd_en    (accept),
		.rd_addr  (col_q),
		.fwd_en   (s1_valid_q && (col_s1 == col_q)),
		.fwd_data (new_pair),
		.rd_data  (rd_pair),
		.wr_en    (s1_adv),
		.wr_addr  (col_s1),
		.wr_data  (new_pair)
	);

	assign col_new = '{top: rd_pair.older, mid: rd_pair.prev, bot: pixel_s1,
		top_ok: flags_s1.row_ge2, mid_ok: flags_s1.row_ge1};
	assign col_chain[0] = col_new;

	// window cells: cell 0 is column C, cell 1 is C-1, cell 2 is C-2
	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		if (k == NUM_CELLS - 1) begin : g_tail
			mg3_cell u_cell (
				.clk      (clk),
				.shift_en (s1_adv),
				.col_in   (col_chain[k]),
				.col_out  (),
				.red      (red[k])
			);
		end else begin : g_body
			mg3_cell u_cell (
				.clk      (clk),
				.shift_en (s1_adv),
				.col_in   (col_chain[k]),
				.col_out  (col_chain[k+1]),
				.red      (red[k])
			);
		end
	end

	// stage 2: results of the item in the window, one per cycle while the output register can take one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2 <= '0;
		end else if (s1_adv) begin
			pend_s2 <= pend_s1;
		end else if (emit) begin
			pend_s2 <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			row_s2   <= row_s1;
			col_s2   <= col_s1;
			flags_s2 <= flags_s1;
		end
	end

	always_comb begin
		sel   = pend_s2 & (~pend_s2 + NUM_SLOTS'(1));
		rest  = pend_s2 & ~sel;
		above = sel[SLOT_ABOVE_LEFT] | sel[SLOT_ABOVE];
		left  = sel[SLOT_ABOVE_LEFT] | sel[SLOT_LEFT];
		inc0  = left && flags_s2.col_ge2;
		inc1  = flags_s2.col_ge1;
		mn    = above ? red[0].lo_all : red[0].lo_low;
		mx    = above ? red[0].hi_all : red[0].hi_low;
		if (inc1) begin
			mn = pix_min(mn, above ? red[1].lo_all : red[1].lo_low);
			mx = pix_max(mx, above ? red[1].hi_all : red[1].hi_low);
		end
		if (inc0) begin
			mn = pix_min(mn, above ? red[2].lo_all : red[2].lo_low);
			mx = pix_max(mx, above ? red[2].hi_all : red[2].hi_low);
		end
		r_c    = above ? row_s2 - RW'(1) : row_s2;
		c_c    = left ? col_s2 - CW'(1) : col_s2;
		r_wide = 32'(r_c);
		c_wide = 32'(c_c);
	end

	assign emit    = (pend_s2 != '0) && (!out_valid_q || out_ready);
	assign s2_free = (pend_s2 == '0) || (emit && (rest == '0));

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			grad_q    <= mx - mn;
			row_out_q <= r_wide[OUT_ROW_W-1:0];
			col_out_q <= c_wide[OUT_COL_W-1:0];
			last_q    <= (rest == '0);
			fend_q    <= sel[SLOT_HERE];
		end
	end

	assign out_valid   = out_valid_q;
	assign gradient    = grad_q;
	assign out_row     = row_out_q;
	assign out_col     = col_out_q;
	assign last_of_run = last_q;
	assign frame_end   = fend_q;

	a_fwd_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s1_valid_q && (col_s1 == col_q)) |-> (w_last_q == '0))
		else $error("line store forward on a frame wider than one pixel");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid_q)
		else $error("accepted item missing from stage 1");

	a_pend_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !s1_adv) |=> ($countones(pend_s2) == $countones($past(pend_s2)) - 1))
		else $error("result slot not retired on emit");

	a_fend_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> last_of_run)
		else $error("frame end item not last of its run");

endmodule

### sv/mg3_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mg3_line_store - two-row line buffer
// One memory holds the two earlier rows per column, one write and one
// registered read a cycle; the read register can take forwarded data.
// ----------------------------------------------------------------------------
module mg3_line_store import mg3_pkg::*; #(
	parameter int DEPTH = DEF_MAX_WIDTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          fwd_en,
	input  line_pair_t    fwd_data,
	output line_pair_t    rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  line_pair_t    wr_data
);

	line_pair_t mem [DEPTH];
	line_pair_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= fwd_en ? fwd_data : mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

### sv/mg3_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mg3_cell - one window column
// Holds three rows of one column, hands them to the next cell on a shift and
// gives the column min/max over all valid rows and over the lower two rows.
// ----------------------------------------------------------------------------
module mg3_cell import mg3_pkg::*; (
	input  logic     clk,
	input  logic     shift_en,
	input  column_t  col_in,
	output column_t  col_out,
	output col_red_t red
);

	column_t col_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			col_q <= col_in;
		end
	end

	always_comb begin
		red.lo_low = col_q.mid_ok ? pix_min(col_q.mid, col_q.bot) : col_q.bot;
		red.hi_low = col_q.mid_ok ? pix_max(col_q.mid, col_q.bot) : col_q.bot;
		red.lo_all = col_q.top_ok ? pix_min(col_q.top, red.lo_low) : red.lo_low;
		red.hi_all = col_q.top_ok ? pix_max(col_q.top, red.hi_low) : red.hi_low;
	end

	assign col_out = col_q;

endmodule
